// ----- src/sdc_pkg.sv -----
// Package for the stride dimension coalescer.
// Holds the request and result types and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdc_pkg;

  localparam int STRIDE_FIELDS   = 4;
  localparam int DEF_MAX_TENSORS = 4;
  localparam int EXT_IN_W        = 32;
  localparam int EXT_W           = 48;
  localparam int STRIDE_W        = 40;
  localparam int CNT_W           = 3;
  localparam int OBUF_DEPTH      = 4;
  localparam int PTR_W           = $clog2(OBUF_DEPTH);

  localparam logic [CNT_W-1:0] TENSORS_RESET = CNT_W'(2);
  localparam logic [EXT_W-1:0] EXTENT_MAX    = {EXT_W{1'b1}};

  typedef struct packed {
    logic [EXT_IN_W-1:0] extent;
    logic [STRIDE_W-1:0] stride_t0;
    logic [STRIDE_W-1:0] stride_t1;
    logic [STRIDE_W-1:0] stride_t2;
    logic [STRIDE_W-1:0] stride_t3;
    logic                final_dim;
  } in_item_t;

  typedef struct packed {
    logic [EXT_W-1:0]    out_extent;
    logic [STRIDE_W-1:0] out_stride_t0;
    logic [STRIDE_W-1:0] out_stride_t1;
    logic [STRIDE_W-1:0] out_stride_t2;
    logic [STRIDE_W-1:0] out_stride_t3;
    logic                out_last;
    logic                extent_overflow;
  } res_item_t;

endpackage
`default_nettype wire

// ----- src/sdc_prod_cmp.sv -----
// Exact test of extent times stride against a held stride for one tensor.
// Uses sdc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module sdc_prod_cmp
  import sdc_pkg::*;
(
  input  wire logic [EXT_IN_W-1:0] ext,
  input  wire logic [STRIDE_W-1:0] stride,
  input  wire logic [STRIDE_W-1:0] target,
  output logic                     eq
);

  localparam int HALF = STRIDE_W / 2;
  localparam int PP_W = EXT_IN_W + STRIDE_W - HALF;
  localparam int PR_W = EXT_IN_W + STRIDE_W;

  logic [PP_W-1:0] p_lo;
  logic [PP_W-1:0] p_hi;
  logic [PR_W-1:0] prod;

  assign p_lo = PP_W'(ext) * PP_W'(stride[HALF-1:0]);
  assign p_hi = PP_W'(ext) * PP_W'(stride[STRIDE_W-1:HALF]);
  assign prod = (PR_W'(p_hi) << HALF) + PR_W'(p_lo);
  assign eq   = (prod == PR_W'(target));

endmodule
`default_nettype wire

// ----- src/sdc_ext_mul.sv -----
// Saturating product of the held extent and an incoming extent.
// Uses sdc_pkg for widths and the saturation value.
`timescale 1ns / 1ps
`default_nettype none
module sdc_ext_mul
  import sdc_pkg::*;
(
  input  wire logic [EXT_W-1:0]    held,
  input  wire logic [EXT_IN_W-1:0] ext,
  output logic [EXT_W-1:0]         prod,
  output logic                     sat
);

  localparam int HALF = EXT_W / 2;
  localparam int PP_W = HALF + EXT_IN_W;
  localparam int PR_W = EXT_W + EXT_IN_W;

  logic [PP_W-1:0] p_lo;
  logic [PP_W-1:0] p_hi;
  logic [PR_W-1:0] full;

  assign p_lo = PP_W'(held[HALF-1:0]) * PP_W'(ext);
  assign p_hi = PP_W'(held[EXT_W-1:HALF]) * PP_W'(ext);
  assign full = (PR_W'(p_hi) << HALF) + PR_W'(p_lo);
  assign sat  = |full[PR_W-1:EXT_W];
  assign prod = sat ? EXTENT_MAX : full[EXT_W-1:0];

endmodule
`default_nettype wire

// ----- src/sdc_out_fifo.sv -----
// Result queue taking up to two results a cycle and giving one while out_stall is low.
// Uses sdc_pkg for the result type and queue depth.
`timescale 1ns / 1ps
`default_nettype none
module sdc_out_fifo
  import sdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire res_item_t push_a,
  input  wire res_item_t push_b,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output res_item_t      out_data
);

  res_item_t        mem_r [OBUF_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= (PTR_W+1)'(OBUF_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push_b;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(OBUF_DEPTH))
    else $error("result queue count beyond depth");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room)
    else $error("result queue written without room");

  a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_cnt == 2'd0) |=> cnt_r == $past(cnt_r) - (PTR_W+1)'(1))
    else $error("result queue count not decremented on a lone pop");

endmodule
`default_nettype wire

// ----- src/stride_dimension_coalescer_unit.sv -----
// Top level of the stride dimension coalescer.
// Uses sdc_pkg, sdc_prod_cmp, sdc_ext_mul and sdc_out_fifo.
//
// Usage: one dimension descriptor per request on the in_ channel, outermost
// dimension first, the innermost one marked by final_dim. Neighbouring
// dimensions that can be walked as one are merged; each coalesced dimension
// leaves as one request on the out_ channel, the last one of a shape marked
// by out_last. The cfg_ channel sets how many tensors are compared; it is
// always ready, and the user must see that it is written only while no
// shape is in flight; the block does not enforce this. Throughput: one
// request accepted per cycle while in_stall is low. A request is held in an
// input register and merged against the held dimension by parallel
// multipliers; its zero, one or two results go into a four-entry queue.
// in_stall rises while the input register is full and the queue holds more
// than two results, so the sustained rate is one request per cycle as long
// as results are taken one per cycle; requests yielding two results lower
// it. A stall on out_ backs up through the queue into in_stall.
// Reset clears the held dimension, empties the queue and sets the tensor
// count to two.
`timescale 1ns / 1ps
`default_nettype none
module stride_dimension_coalescer_unit
  import sdc_pkg::*;
#(
  parameter int MAX_TENSORS = DEF_MAX_TENSORS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output res_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int LANES = (MAX_TENSORS < STRIDE_FIELDS) ? MAX_TENSORS : STRIDE_FIELDS;

  logic [CNT_W-1:0]    tensors_r;
  logic                stage_v_r, stage_v_nxt;
  in_item_t            item_r;
  logic                holding_r, holding_nxt;
  logic [EXT_W-1:0]    held_ext_r, held_ext_nxt;
  logic [STRIDE_W-1:0] held_st_r [LANES];
  logic [STRIDE_W-1:0] held_st_nxt [LANES];
  logic                held_ovf_r, held_ovf_nxt;

  logic                fire, accept, room;
  logic [CNT_W-1:0]    n_eff;
  logic [LANES-1:0]    en, eq;
  logic [STRIDE_W-1:0] st [STRIDE_FIELDS];
  logic                all_eq, merge, split, ext_one;
  logic [EXT_W-1:0]    ext_prod;
  logic                ext_sat;

  logic                mid_hold;
  logic [EXT_W-1:0]    mid_ext;
  logic [STRIDE_W-1:0] mid_st [LANES];
  logic                mid_ovf;

  logic [STRIDE_W-1:0] pre_em [STRIDE_FIELDS];
  logic [STRIDE_W-1:0] post_em [STRIDE_FIELDS];
  res_item_t           res_pre, res_post, push_a;
  logic [1:0]          push_cnt;

  assign cfg_ready = 1'b1;
  assign in_stall  = stage_v_r && !room;
  assign accept    = in_valid && !in_stall;
  assign fire      = stage_v_r && room;
  assign stage_v_nxt = accept || (stage_v_r && !fire);

  assign st[0] = item_r.stride_t0;
  assign st[1] = item_r.stride_t1;
  assign st[2] = item_r.stride_t2;
  assign st[3] = item_r.stride_t3;

  always_comb begin
    if (tensors_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (tensors_r > CNT_W'(LANES)) begin
      n_eff = CNT_W'(LANES);
    end else begin
      n_eff = tensors_r;
    end
  end

  for (genvar t = 0; t < LANES; t++) begin : g_lane
    assign en[t] = (CNT_W'(t) < n_eff);
    sdc_prod_cmp u_cmp (
      .ext    (item_r.extent),
      .stride (st[t]),
      .target (held_st_r[t]),
      .eq     (eq[t])
    );
  end

  for (genvar t = 0; t < STRIDE_FIELDS; t++) begin : g_emit
    if (t < LANES) begin : g_used
      assign pre_em[t]  = en[t] ? held_st_r[t] : '0;
      assign post_em[t] = en[t] ? mid_st[t] : '0;
    end else begin : g_unused
      assign pre_em[t]  = '0;
      assign post_em[t] = '0;
    end
  end

  sdc_ext_mul u_mul (
    .held (held_ext_r),
    .ext  (item_r.extent),
    .prod (ext_prod),
    .sat  (ext_sat)
  );

  assign all_eq  = &(eq | ~en);
  assign ext_one = (item_r.extent == EXT_IN_W'(1));
  assign merge   = (held_ext_r == EXT_W'(1)) || ext_one || all_eq;
  assign split   = holding_r && !merge;

  always_comb begin
    mid_hold = 1'b1;
    mid_ext  = held_ext_r;
    mid_ovf  = held_ovf_r;
    for (int t = 0; t < LANES; t++) begin
      mid_st[t] = held_st_r[t];
    end
    if (!holding_r || !merge) begin
      mid_ext = EXT_W'(item_r.extent);
      mid_ovf = 1'b0;
      for (int t = 0; t < LANES; t++) begin
        mid_st[t] = en[t] ? st[t] : '0;
      end
    end else begin
      mid_ext = ext_prod;
      mid_ovf = held_ovf_r || ext_sat;
      if (!ext_one) begin
        for (int t = 0; t < LANES; t++) begin
          if (en[t]) begin
            mid_st[t] = st[t];
          end
        end
      end
    end
  end

  always_comb begin
    holding_nxt  = holding_r;
    held_ext_nxt = held_ext_r;
    held_ovf_nxt = held_ovf_r;
    for (int t = 0; t < LANES; t++) begin
      held_st_nxt[t] = held_st_r[t];
    end
    if (fire) begin
      if (item_r.final_dim) begin
        holding_nxt  = 1'b0;
        held_ext_nxt = '0;
        held_ovf_nxt = 1'b0;
        for (int t = 0; t < LANES; t++) begin
          held_st_nxt[t] = '0;
        end
      end else begin
        holding_nxt  = mid_hold;
        held_ext_nxt = mid_ext;
        held_ovf_nxt = mid_ovf;
        for (int t = 0; t < LANES; t++) begin
          held_st_nxt[t] = mid_st[t];
        end
      end
    end
  end

  always_comb begin
    res_pre.out_extent      = held_ext_r;
    res_pre.out_stride_t0   = pre_em[0];
    res_pre.out_stride_t1   = pre_em[1];
    res_pre.out_stride_t2   = pre_em[2];
    res_pre.out_stride_t3   = pre_em[3];
    res_pre.out_last        = 1'b0;
    res_pre.extent_overflow = held_ovf_r;

    res_post.out_extent      = mid_ext;
    res_post.out_stride_t0   = post_em[0];
    res_post.out_stride_t1   = post_em[1];
    res_post.out_stride_t2   = post_em[2];
    res_post.out_stride_t3   = post_em[3];
    res_post.out_last        = 1'b1;
    res_post.extent_overflow = mid_ovf;

    push_a   = split ? res_pre : res_post;
    push_cnt = 2'd0;
    if (fire) begin
      push_cnt = 2'(split) + 2'(item_r.final_dim);
    end
  end

  sdc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (res_post),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tensors_r  <= TENSORS_RESET;
      stage_v_r  <= 1'b0;
      holding_r  <= 1'b0;
      held_ext_r <= '0;
      held_ovf_r <= 1'b0;
      for (int t = 0; t < LANES; t++) begin
        held_st_r[t] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        tensors_r <= cfg_data;
      end
      stage_v_r  <= stage_v_nxt;
      holding_r  <= holding_nxt;
      held_ext_r <= held_ext_nxt;
      held_ovf_r <= held_ovf_nxt;
      for (int t = 0; t < LANES; t++) begin
        held_st_r[t] <= held_st_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.final_dim) |=> !holding_r)
    else $error("held dimension survives the last request of a shape");

  a_first_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !item_r.final_dim) |=> holding_r)
    else $error("non-final request left nothing held");

  a_ovf_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    held_ovf_r |-> holding_r)
    else $error("overflow flag set with nothing held");

  a_idle_ext_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !holding_r |-> (held_ext_r == '0))
    else $error("held extent non-zero with nothing held");

endmodule
`default_nettype wire

// ----- bench/sdc_merge_checker.sv -----
// Checker for the stride dimension coalescer: watches the cfg_, in_ and out_ channels.
// Predicts each coalesced dimension and compares it field by field. Uses sdc_pkg.
`timescale 1ns / 1ps
module sdc_merge_checker
  import sdc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_stall,
  input  wire in_item_t         in_data,
  input  wire logic             out_valid,
  input  wire logic             out_stall,
  input  wire res_item_t        out_data,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_pending
);

  logic [CNT_W-1:0]    tensor_count = TENSORS_RESET;
  logic [EXT_W-1:0]    held_extent = '0;
  logic [STRIDE_W-1:0] held_strides [STRIDE_FIELDS];
  logic                held_valid = 1'b0;
  logic                held_overflow = 1'b0;
  res_item_t           expected_dims [$];
  int                  errors = 0;

  initial begin
    fail_count = 0;
    results_pending = 0;
  end

  function automatic int active_tensors();
    int n;
    n = int'(tensor_count);
    if (n == 0) n = 1;
    if (n > STRIDE_FIELDS) n = STRIDE_FIELDS;
    if (n > DEF_MAX_TENSORS) n = DEF_MAX_TENSORS;
    return n;
  endfunction

  function automatic logic [STRIDE_W-1:0] stride_of(in_item_t d, int t);
    case (t)
      0: return d.stride_t0;
      1: return d.stride_t1;
      2: return d.stride_t2;
      default: return d.stride_t3;
    endcase
  endfunction

  function automatic res_item_t held_dimension(logic last);
    res_item_t r;
    int n;
    n = active_tensors();
    r.out_extent      = held_extent;
    r.out_stride_t0   = (n > 0) ? held_strides[0] : '0;
    r.out_stride_t1   = (n > 1) ? held_strides[1] : '0;
    r.out_stride_t2   = (n > 2) ? held_strides[2] : '0;
    r.out_stride_t3   = (n > 3) ? held_strides[3] : '0;
    r.out_last        = last;
    r.extent_overflow = held_overflow;
    return r;
  endfunction

  task automatic clear_held();
    held_valid = 1'b0;
    held_extent = '0;
    held_overflow = 1'b0;
    for (int t = 0; t < STRIDE_FIELDS; t++) held_strides[t] = '0;
  endtask

  task automatic hold_dimension(in_item_t d);
    int n;
    n = active_tensors();
    held_extent = EXT_W'(d.extent);
    for (int t = 0; t < STRIDE_FIELDS; t++) held_strides[t] = (t < n) ? stride_of(d, t) : '0;
    held_overflow = 1'b0;
    held_valid = 1'b1;
  endtask

  task automatic predict_dimension(in_item_t d);
    int n;
    logic merge;
    logic [79:0] prod;
    n = active_tensors();
    if (!held_valid) begin
      hold_dimension(d);
    end else begin
      merge = (held_extent == 1) || (d.extent == 1);
      if (!merge) begin
        merge = 1'b1;
        for (int t = 0; t < n; t++) begin
          if (80'(d.extent) * 80'(stride_of(d, t)) != 80'(held_strides[t])) merge = 1'b0;
        end
      end
      if (merge) begin
        if (d.extent != 1) begin
          for (int t = 0; t < n; t++) held_strides[t] = stride_of(d, t);
        end
        prod = 80'(held_extent) * 80'(d.extent);
        if (prod > 80'(EXTENT_MAX)) begin
          held_extent = EXTENT_MAX;
          held_overflow = 1'b1;
        end else begin
          held_extent = prod[EXT_W-1:0];
        end
      end else begin
        expected_dims.push_back(held_dimension(1'b0));
        hold_dimension(d);
      end
    end
    if (d.final_dim) begin
      expected_dims.push_back(held_dimension(1'b1));
      clear_held();
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (!rst_n) begin
      tensor_count = TENSORS_RESET;
      clear_held();
      expected_dims.delete();
    end else begin
      if (cfg_valid && cfg_ready) tensor_count = cfg_data;
      if (in_valid && !in_stall) predict_dimension(in_data);
      if (out_valid && !out_stall) begin
        if (expected_dims.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = expected_dims.pop_front();
          check_field("out_extent", want.out_extent, out_data.out_extent);
          check_field("out_stride_t0", want.out_stride_t0, out_data.out_stride_t0);
          check_field("out_stride_t1", want.out_stride_t1, out_data.out_stride_t1);
          check_field("out_stride_t2", want.out_stride_t2, out_data.out_stride_t2);
          check_field("out_stride_t3", want.out_stride_t3, out_data.out_stride_t3);
          check_field("out_last", want.out_last, out_data.out_last);
          check_field("extent_overflow", want.extent_overflow, out_data.extent_overflow);
        end
      end
    end
    results_pending <= expected_dims.size();
    fail_count <= errors;
  end

endmodule

// ----- bench/stride_dimension_coalescer_unit_tb.sv -----
// Testbench top for the stride dimension coalescer: drives shapes and the tensor count.
// Depends on sdc_pkg, sdc_merge_checker and the block under test.
`timescale 1ns / 1ps
module stride_dimension_coalescer_unit_tb;
  import sdc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 90;
  localparam logic [STRIDE_W-1:0] STRIDE_TOP = {STRIDE_W{1'b1}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  in_item_t         in_data = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_stall;
  logic             out_valid;
  res_item_t        out_data;
  logic             cfg_ready;
  int               fail_count;
  int               results_pending;

  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  stride_dimension_coalescer_unit DUT (.*);

  sdc_merge_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stride_dimension_coalescer_unit_tb: errors");
      $finish;
    end
  end

  // The receiver either holds off for a long stretch once asked, or, while rx_gaps_on is set, stalls at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 79;
      hold_done <= 1'b1;
    end else begin
      out_stall <= rx_gaps_on && ($urandom_range(99) < 23);
    end
  end

  function automatic in_item_t make_dim(logic [EXT_IN_W-1:0] ext, logic [STRIDE_W-1:0] s0,
                                        logic [STRIDE_W-1:0] s1, logic [STRIDE_W-1:0] s2,
                                        logic [STRIDE_W-1:0] s3, logic fin);
    in_item_t d;
    d.extent = ext;
    d.stride_t0 = s0;
    d.stride_t1 = s1;
    d.stride_t2 = s2;
    d.stride_t3 = s3;
    d.final_dim = fin;
    return d;
  endfunction

  function automatic logic [EXT_IN_W-1:0] random_extent();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 20) return 1;
    if (r < 85) return $urandom_range(2, 9);
    return $urandom;
  endfunction

  function automatic logic [STRIDE_W-1:0] full_stride();
    return STRIDE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [STRIDE_W-1:0] random_stride();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 80) return STRIDE_W'($urandom_range(1, 64));
    return full_stride();
  endfunction

  task automatic offer_dimension(in_item_t d);
    while (tx_gaps_on && ($urandom_range(99) < 23)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tensor_count(logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A shape built innermost first, so that outer strides mostly continue the inner ones.
  task automatic send_random_shape(inout int sent);
    int depth;
    logic [EXT_IN_W-1:0] ext [8];
    logic [STRIDE_W-1:0] st [8][STRIDE_FIELDS];
    bit contiguous;
    depth = $urandom_range(1, 6);
    for (int i = depth - 1; i >= 0; i--) begin
      ext[i] = random_extent();
      contiguous = (i != depth - 1) && ($urandom_range(99) < 70);
      for (int t = 0; t < STRIDE_FIELDS; t++) begin
        if (contiguous && ($urandom_range(99) < 92))
          st[i][t] = STRIDE_W'(80'(ext[i + 1]) * 80'(st[i + 1][t]));
        else
          st[i][t] = random_stride();
      end
    end
    for (int i = 0; i < depth; i++) begin
      offer_dimension(make_dim(ext[i], st[i][0], st[i][1], st[i][2], st[i][3],
                               i == depth - 1));
      sent++;
    end
  endtask

  task automatic send_noise(inout int sent);
    int count;
    count = $urandom_range(1, 5);
    for (int i = 0; i < count; i++) begin
      offer_dimension(make_dim($urandom, full_stride(), full_stride(), full_stride(),
                               full_stride(), (i == count - 1) || ($urandom_range(99) < 20)));
      sent++;
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts [8];
    int sent;
    counts = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2, 3'd4};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset tensor count of two: first dimension final, full-width fields.
    offer_dimension(make_dim(32'hFFFF_FFFF, STRIDE_TOP, STRIDE_TOP, STRIDE_TOP, STRIDE_TOP, 1));
    // Contiguous shape that collapses into one dimension.
    offer_dimension(make_dim(3, 20, 40, 7, 9, 0));
    offer_dimension(make_dim(5, 4, 8, 0, 0, 0));
    offer_dimension(make_dim(4, 1, 2, 0, 0, 1));
    // Strides that do not line up, so the final request yields two results.
    offer_dimension(make_dim(3, 10, 10, 0, 0, 0));
    offer_dimension(make_dim(2, 4, 5, 0, 0, 1));
    // Held extent of one takes over the incoming strides.
    offer_dimension(make_dim(1, 100, 200, 0, 0, 0));
    offer_dimension(make_dim(7, 3, 5, 0, 0, 1));
    // Incoming extent of one keeps the held strides.
    offer_dimension(make_dim(6, 9, 9, 0, 0, 0));
    offer_dimension(make_dim(1, 77, 77, 0, 0, 1));
    // Saturation, then a factor of zero with the flag kept, then saturation on the final request.
    offer_dimension(make_dim(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    offer_dimension(make_dim(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    offer_dimension(make_dim(0, 0, 0, 0, 0, 1));
    offer_dimension(make_dim(32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    offer_dimension(make_dim(32'hFFFF_FFFF, 0, 0, 0, 0, 1));
    // A product that would wrap to the held stride in 40 bits must not merge.
    offer_dimension(make_dim(3, 0, 0, 0, 0, 0));
    offer_dimension(make_dim(2, 40'h80_0000_0000, 40'h80_0000_0000, 0, 0, 1));
    // Zero extents with non-zero held strides.
    offer_dimension(make_dim(0, 5, 5, 0, 0, 0));
    offer_dimension(make_dim(0, 0, 0, 0, 0, 1));
    offer_dimension(make_dim(2, 1, 1, 3, 3, 0));
    offer_dimension(make_dim(2, 0, 0, STRIDE_TOP, STRIDE_TOP, 1));
    drain_results();

    for (int p = 0; p < 8; p++) begin
      write_tensor_count(counts[p]);
      tx_gaps_on = (p != 2);
      rx_gaps_on <= (p != 2);
      if (p == 4) long_hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) send_random_shape(sent);
        else send_noise(sent);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("stride_dimension_coalescer_unit_tb: clean");
    end else begin
      $display("stride_dimension_coalescer_unit_tb: errors");
    end
    $finish;
  end

endmodule
